// File: design/power_monitor_reading_conversion_top_assert.svh
// ----------------------------------------------------------------------------
// Power monitor reading conversion: assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef POWER_MONITOR_READING_CONVERSION_TOP_ASSERT_SVH
`define POWER_MONITOR_READING_CONVERSION_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PMRC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pmrc assertion failed");

// Next-cycle implication, disabled during reset
`define PMRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pmrc assertion failed");

`endif

// File: design/pmrc_pkg.sv
// ----------------------------------------------------------------------------
// Power monitor reading conversion: package
// Shared types, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package pmrc_pkg;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SHUNT_MILLIOHMS  = 3'd0;
    localparam logic [2:0] REG_ZERO_BAND        = 3'd1;
    localparam logic [2:0] REG_SUBTRACT_DROP    = 3'd2;
    localparam logic [2:0] REG_ALARM_ENABLE     = 3'd3;
    localparam logic [2:0] REG_ALARM_MILLIWATTS = 3'd4;

    // Reset values
    localparam logic [15:0] SHUNT_RESET = 16'd100;

    // Field widths
    localparam int SHUNT_W = 16;
    localparam int BUS_W   = 15;
    localparam int UVOLT_W = 22;
    localparam int QUO_W   = 27;
    localparam int CUR_W   = 28;
    localparam int EXP_W   = 5;

    // Serial divider iterations, one quotient bit each
    localparam int DIV_STEPS = QUO_W;

    // Scaling and normalization constants
    localparam logic [QUO_W-1:0] CUR_SCALE  = 27'd2500;  // 25 * 100
    localparam logic [31:0]      RECIP10    = 32'hCCCC_CCCD; // 2^35 / 10, rounded up
    localparam int               RECIP_SH   = 35;
    localparam logic [QUO_W-1:0] NORM_LIMIT = 27'd10000;

    // Power exponent starts at -6 + -5; milliwatt exponent is -3
    localparam logic signed [EXP_W-1:0] EXP_BASE  = -5'sd11;
    localparam logic [3:0]              MW_SHIFT  = 4'd8;

    typedef struct packed {
        logic [15:0] shunt_milliohms;
        logic [14:0] zero_band;
        logic        subtract_drop;
        logic        alarm_enable;
        logic [21:0] alarm_milliwatts;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM_I,
        ST_NORM_U,
        ST_PROD,
        ST_ALARM,
        ST_DONE
    } state_t;

endpackage

// File: design/pmrc_cfg.sv
// ----------------------------------------------------------------------------
// Power monitor reading conversion: configuration registers
// APB-style register file; writes in the access phase, reads are direct.
// ----------------------------------------------------------------------------
module pmrc_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output pmrc_pkg::cfg_t     cfg
);
    import pmrc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Decode the write word into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_SHUNT_MILLIOHMS:  cfg_next.shunt_milliohms  = pwdata[15:0];
                REG_ZERO_BAND:        cfg_next.zero_band        = pwdata[14:0];
                REG_SUBTRACT_DROP:    cfg_next.subtract_drop    = pwdata[0];
                REG_ALARM_ENABLE:     cfg_next.alarm_enable     = pwdata[0];
                REG_ALARM_MILLIWATTS: cfg_next.alarm_milliwatts = pwdata[21:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shunt_milliohms  <= SHUNT_RESET;
            cfg_reg.zero_band        <= '0;
            cfg_reg.subtract_drop    <= 1'b0;
            cfg_reg.alarm_enable     <= 1'b0;
            cfg_reg.alarm_milliwatts <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb begin
        case (idx)
            REG_SHUNT_MILLIOHMS:  prdata = {16'd0, cfg_reg.shunt_milliohms};
            REG_ZERO_BAND:        prdata = {17'd0, cfg_reg.zero_band};
            REG_SUBTRACT_DROP:    prdata = {31'd0, cfg_reg.subtract_drop};
            REG_ALARM_ENABLE:     prdata = {31'd0, cfg_reg.alarm_enable};
            REG_ALARM_MILLIWATTS: prdata = {10'd0, cfg_reg.alarm_milliwatts};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// File: design/pmrc_div.sv
// ----------------------------------------------------------------------------
// Power monitor reading conversion: serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmrc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pmrc_pkg::QUO_W-1:0]  dividend,
    input  logic [15:0]                 divisor,
    output logic [pmrc_pkg::QUO_W-1:0]  quotient,
    output pmrc_pkg::div_status_t       status
);
    import pmrc_pkg::*;

    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dvs_reg, dvs_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [16:0]      rem_shift;
    logic [16:0]      diff;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder
    assign rem_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[QUO_W-2:0], fits};
            rem_next = fits ? diff[15:0] : rem_shift[15:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: design/pmrc_mul.sv
// ----------------------------------------------------------------------------
// Power monitor reading conversion: shared multiplier
// One 32x32 unsigned multiplier, used for divide-by-ten and the power product.
// ----------------------------------------------------------------------------
module pmrc_mul (
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);
    // Full-width product; the caller registers the slice it needs
    assign prod = {32'd0, op_a} * {32'd0, op_b};

endmodule

// File: design/power_monitor_reading_conversion_top.sv
// ----------------------------------------------------------------------------
// Power monitor reading conversion: top level
// Most of the time from input word to result word goes to the serial divider
// for the current; after it the shared multiplier takes each divide-by-ten, the
// product and each alarm scale step in turn. s_tready is high only in the idle
// state, so a new word is taken only once the last result word is registered.
// Reset: aresetn synchronous, active low; control registers take their reset values.
// ----------------------------------------------------------------------------
module power_monitor_reading_conversion_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] shunt_code, [30:16] bus_code, [31] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [21:0] bus_centimv, [49:22] current_microamps,
                                   // [77:50] power_mantissa, [82:78] power_exponent,
                                   // [83] alarm_flag, [87:84] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pmrc_pkg::*;

    cfg_t              cfg;
    div_status_t       div_sts;
    logic [QUO_W-1:0]  quotient;

    state_t            state_reg, state_next;
    logic              neg_reg, neg_next;
    logic [UVOLT_W-1:0] bus_reg, bus_next;
    logic [UVOLT_W-1:0] umag_reg, umag_next;
    logic [QUO_W-1:0]  imag_reg, imag_next;
    logic [CUR_W-1:0]  cur_reg, cur_next;
    logic [QUO_W-1:0]  prod_reg, prod_next;
    logic [QUO_W-1:0]  lhs_reg, lhs_next;
    logic [3:0]        ncnt_reg, ncnt_next;
    logic [3:0]        acnt_reg, acnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [87:0]       m_tdata_reg, m_tdata_next;

    logic              s_accept;
    logic [SHUNT_W-1:0] shunt;
    logic [BUS_W-1:0]  bus;
    logic [SHUNT_W-1:0] shunt_abs;
    logic              in_band;
    logic [SHUNT_W-1:0] s_mag;
    logic [13:0]       drop;
    logic [UVOLT_W-1:0] u0;
    logic [UVOLT_W-1:0] u_in;
    logic [QUO_W-1:0]  dividend;
    logic [15:0]       divisor;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [QUO_W-1:0]  q10;
    logic [CUR_W-1:0]  mant;
    logic [EXP_W-1:0]  pexp;
    logic              alarm;

    pmrc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: zero band, voltage scaling, optional drop subtraction
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign shunt     = s_tdata[15:0];
    assign bus       = s_tdata[30:16];
    assign shunt_abs = shunt[SHUNT_W-1] ? (~shunt + 16'd1) : shunt;
    assign in_band   = shunt_abs <= {1'b0, cfg.zero_band};
    assign s_mag     = in_band ? '0 : shunt_abs;
    assign drop      = s_mag[15:2];
    assign u0        = ({7'd0, bus} << 7) - ({7'd0, bus} << 2) + {7'd0, bus};
    assign u_in      = (cfg.subtract_drop && ({8'd0, drop} < u0)) ? (u0 - {8'd0, drop}) : u0;
    assign dividend  = {11'd0, s_mag} * CUR_SCALE;
    assign divisor   = (cfg.shunt_milliohms == 16'd0) ? 16'd1 : cfg.shunt_milliohms;

    pmrc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_sts)
    );

    // Steer the shared multiplier by sequencer state
    always_comb begin
        case (state_reg)
            ST_NORM_U: begin
                mul_a = {10'd0, umag_reg};
                mul_b = RECIP10;
            end
            ST_PROD: begin
                mul_a = {5'd0, imag_reg};
                mul_b = {10'd0, umag_reg};
            end
            ST_ALARM: begin
                mul_a = {5'd0, lhs_reg};
                mul_b = RECIP10;
            end
            default: begin
                mul_a = {5'd0, imag_reg};
                mul_b = RECIP10;
            end
        endcase
    end

    pmrc_mul u_mul (
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign q10   = mul_p[RECIP_SH+QUO_W-1:RECIP_SH];
    assign mant  = neg_reg ? (~{1'b0, prod_reg} + 28'd1) : {1'b0, prod_reg};
    assign pexp  = EXP_BASE + {1'b0, ncnt_reg};
    assign alarm = cfg.alarm_enable && (lhs_reg >= {5'd0, cfg.alarm_milliwatts});

    // Sequencer: divide, normalize both mantissas, multiply, scale for alarm
    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        bus_next      = bus_reg;
        umag_next     = umag_reg;
        imag_next     = imag_reg;
        cur_next      = cur_reg;
        prod_next     = prod_reg;
        lhs_next      = lhs_reg;
        ncnt_next     = ncnt_reg;
        acnt_next     = acnt_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    neg_next   = shunt[SHUNT_W-1] && !in_band;
                    bus_next   = u_in;
                    umag_next  = u_in;
                    ncnt_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    imag_next  = quotient;
                    cur_next   = neg_reg ? (~{1'b0, quotient} + 28'd1) : {1'b0, quotient};
                    state_next = ST_NORM_I;
                end
            end
            ST_NORM_I: begin
                if (imag_reg > NORM_LIMIT) begin
                    imag_next = q10;
                    ncnt_next = ncnt_reg + 4'd1;
                end else begin
                    state_next = ST_NORM_U;
                end
            end
            ST_NORM_U: begin
                if (umag_reg > NORM_LIMIT[UVOLT_W-1:0]) begin
                    umag_next = q10[UVOLT_W-1:0];
                    ncnt_next = ncnt_reg + 4'd1;
                end else begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                prod_next  = mul_p[QUO_W-1:0];
                lhs_next   = mul_p[QUO_W-1:0];
                acnt_next  = MW_SHIFT - ncnt_reg;
                state_next = ST_ALARM;
            end
            ST_ALARM: begin
                // floor(p / 10^k) >= threshold exactly when p >= threshold * 10^k
                if (cfg.alarm_enable && (acnt_reg != 4'd0)) begin
                    lhs_next  = q10;
                    acnt_next = acnt_reg - 4'd1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {4'd0, alarm, pexp, mant, cur_reg, bus_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg     <= neg_next;
        bus_reg     <= bus_next;
        umag_reg    <= umag_next;
        imag_reg    <= imag_next;
        cur_reg     <= cur_next;
        prod_reg    <= prod_next;
        lhs_reg     <= lhs_next;
        ncnt_reg    <= ncnt_next;
        acnt_reg    <= acnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/pmrc_checker.sv
// ----------------------------------------------------------------------------
// Power monitor reading conversion: port checker
// Watches the top-level ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
`include "power_monitor_reading_conversion_top_assert.svh"

module pmrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        pready
);
    // Register port never waits
    `PMRC_ASSERT_IMPLY(a_pready_high, aclk, aresetn, 1'b1, pready)

    // Busy for at least the cycle after an accepted word
    `PMRC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Hold a result word until it is taken
    `PMRC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Zero current gives zero power mantissa
    `PMRC_ASSERT_IMPLY(a_zero_power, aclk, aresetn, m_tvalid && (m_tdata[49:22] == 28'd0), m_tdata[77:50] == 28'd0)

endmodule

bind power_monitor_reading_conversion_top pmrc_checker u_pmrc_checker (.*);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Power monitor reading conversion: testbench
// Streams raw shunt/bus readings through the block under several register
// settings and checks every result word against a local prediction of the
// scaled bus voltage, current, normalized power and alarm flag. Both stream
// sides idle at random, and the result side holds off once to back up the
// input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmrc_pkg::*;

    localparam int MAX_IDLE        = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_WORDS     = 53;

    // Predicts result words from readings and holds them until they arrive
    class reading_scoreboard;
        cfg_t        cfg;
        logic [87:0] expected_q[$];
        int          errors;

        function new();
            cfg = '0;
            cfg.shunt_milliohms = SHUNT_RESET;
            errors = 0;
        endfunction

        // Track register writes as the block sees them
        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_SHUNT_MILLIOHMS:  cfg.shunt_milliohms  = value[15:0];
                REG_ZERO_BAND:        cfg.zero_band        = value[14:0];
                REG_SUBTRACT_DROP:    cfg.subtract_drop    = value[0];
                REG_ALARM_ENABLE:     cfg.alarm_enable     = value[0];
                REG_ALARM_MILLIWATTS: cfg.alarm_milliwatts = value[21:0];
                default: ;
            endcase
        endfunction

        function logic [87:0] convert_reading(logic [15:0] shunt_raw, logic [14:0] bus_raw);
            longint shunt_val, band, shunt_tenth_uv, bus_val, drop, divisor, current;
            longint cur_mag, bus_mag, product, power_mant, lhs, rhs;
            int     cur_exp, bus_exp, power_exp, shift;
            bit     negative, alarm;
            logic [87:0] word;
            // Force codes inside the dead band to zero, then scale
            shunt_val = $signed(shunt_raw);
            band = cfg.zero_band;
            if (shunt_val >= -band && shunt_val <= band)
                shunt_val = 0;
            shunt_tenth_uv = shunt_val * 25;
            bus_val = longint'(bus_raw) * 125;
            // Remove the shunt drop only while it is smaller than the bus voltage
            if (cfg.subtract_drop) begin
                drop = shunt_tenth_uv / 100;
                if (drop < 0)
                    drop = -drop;
                if (drop < bus_val)
                    bus_val -= drop;
            end
            divisor = (cfg.shunt_milliohms == 0) ? 1 : cfg.shunt_milliohms;
            current = (shunt_tenth_uv * 100) / divisor;
            // Normalize magnitudes to at most 10000 with decimal exponents
            negative = current < 0;
            cur_mag = negative ? -current : current;
            cur_exp = -6;
            while (cur_mag > 10000) begin
                cur_mag /= 10;
                cur_exp++;
            end
            bus_mag = bus_val;
            bus_exp = -5;
            while (bus_mag > 10000) begin
                bus_mag /= 10;
                bus_exp++;
            end
            product = cur_mag * bus_mag;
            power_exp = cur_exp + bus_exp;
            power_mant = negative ? -product : product;
            // Exact compare of power magnitude against the milliwatt threshold
            alarm = 0;
            if (cfg.alarm_enable) begin
                lhs = product;
                rhs = cfg.alarm_milliwatts;
                shift = power_exp + 3;
                while (shift > 0) begin
                    lhs *= 10;
                    shift--;
                end
                while (shift < 0) begin
                    rhs *= 10;
                    shift++;
                end
                alarm = lhs >= rhs;
            end
            word = '0;
            word[21:0]  = bus_val[21:0];
            word[49:22] = current[27:0];
            word[77:50] = power_mant[27:0];
            word[82:78] = power_exp[4:0];
            word[83]    = alarm;
            return word;
        endfunction

        function void note_reading(logic [31:0] word);
            expected_q.push_back(convert_reading(word[15:0], word[30:16]));
        endfunction

        function void compare_field(string name, logic [27:0] exp_val, logic [27:0] act_val);
            if (exp_val !== act_val) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [87:0] actual);
            logic [87:0] expected;
            if (expected_q.size() == 0) begin
                $display("%0t: result word with nothing expected, expected none, actual %h",
                         $time, actual);
                errors++;
                return;
            end
            expected = expected_q.pop_front();
            compare_field("bus_centimv", expected[21:0], actual[21:0]);
            compare_field("current_microamps", expected[49:22], actual[49:22]);
            compare_field("power_mantissa", expected[77:50], actual[77:50]);
            compare_field("power_exponent", expected[82:78], actual[82:78]);
            compare_field("alarm_flag", expected[83], actual[83]);
            compare_field("pad", expected[87:84], actual[87:84]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] shunt_code, [30:16] bus_code, [31] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // [21:0] bus_centimv, [49:22] current_microamps,
                            // [77:50] power_mantissa, [82:78] power_exponent,
                            // [83] alarm_flag, [87:84] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    reading_scoreboard sb;
    bit no_idle;
    bit hold_off_req;

    power_monitor_reading_conversion_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one reading after a random gap and hold it until accepted
    task automatic send_reading(logic [15:0] shunt, logic [14:0] bus);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, bus, shunt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_reading({1'b0, bus, shunt});
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // Setup then access cycle; psel stays up between back-to-back writes
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(logic [15:0] shunt_mohm, logic [14:0] band, logic sub,
                             logic alarm_en, logic [21:0] alarm_mw);
        apb_write(REG_SHUNT_MILLIOHMS, {16'b0, shunt_mohm});
        apb_write(REG_ZERO_BAND, {17'b0, band});
        apb_write(REG_SUBTRACT_DROP, {31'b0, sub});
        apb_write(REG_ALARM_ENABLE, {31'b0, alarm_en});
        apb_write(REG_ALARM_MILLIWATTS, {10'b0, alarm_mw});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: random stall per word, one long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata);
        end
    end

    // Watchdog: end the run after too long without any handshake
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("power_monitor_reading_conversion_top regression: fail");
        $finish;
    end

    // Stimulus
    initial begin
        int          p, n;
        logic [15:0] sh_mohm, shunt;
        logic [14:0] zb, bus;
        logic [21:0] mw;
        logic        sub, en;
        sb = new();
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: field extremes and normalization boundaries
        send_reading(16'h0000, 15'd0);
        send_reading(16'h7FFF, 15'h7FFF);
        send_reading(16'h8000, 15'h7FFF);
        send_reading(16'hFFFF, 15'd1);
        send_reading(16'h0001, 15'd0);
        send_reading(16'd400, 15'd80);
        send_reading(16'd401, 15'd81);
        send_reading(-16'sd400, 15'd80);
        send_reading(-16'sd401, 15'd81);
        send_reading(16'h8000, 15'd0);
        drain();

        // Zero resistance, widest dead band, zero alarm threshold
        configure(16'd0, 15'h7FFF, 1'b1, 1'b1, 22'd0);
        send_reading(16'h8000, 15'h7FFF);
        send_reading(16'h7FFF, 15'd5);
        send_reading(16'h0000, 15'd0);
        drain();

        // Smallest resistance, top threshold, drop larger than bus voltage
        configure(16'd1, 15'd0, 1'b1, 1'b1, 22'h3FFFFF);
        send_reading(16'h7FFF, 15'd0);
        send_reading(16'h8000, 15'h7FFF);
        send_reading(16'd100, 15'd1);
        send_reading(-16'sd100, 15'h7FFF);
        send_reading(16'h7FFF, 15'h7FFF);
        drain();

        // Largest resistance, dead band edges, alarm disabled
        configure(16'hFFFF, 15'd10, 1'b0, 1'b0, 22'd1);
        send_reading(16'd10, 15'd100);
        send_reading(16'd11, 15'd100);
        send_reading(-16'sd10, 15'd100);
        send_reading(-16'sd11, 15'd100);
        drain();

        // Random settings and readings
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0: sh_mohm = 16'd1;
                1: sh_mohm = 16'hFFFF;
                2: sh_mohm = 16'($urandom_range(1, 1000));
                default: sh_mohm = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 3))
                0: zb = 15'd0;
                1: zb = 15'($urandom_range(0, 50));
                2: zb = 15'($urandom_range(0, 32767));
                default: zb = 15'($urandom_range(0, 2000));
            endcase
            case ($urandom_range(0, 3))
                0: mw = 22'd0;
                1: mw = 22'h3FFFFF;
                2: mw = 22'($urandom_range(0, 4194303));
                default: mw = 22'($urandom_range(0, 3000));
            endcase
            sub = 1'($urandom_range(0, 1));
            en  = ($urandom_range(0, 3) != 0);
            configure(sh_mohm, zb, sub, en, mw);
            no_idle = (p == 1) || ($urandom_range(0, 3) == 0);
            if (p == 0)
                hold_off_req = 1'b1;
            for (n = 0; n < PHASE_WORDS; n++) begin
                case ($urandom_range(0, 4))
                    0, 1: shunt = 16'($urandom_range(0, 65535));
                    2: shunt = 16'($urandom_range(0, 1000) - 500);
                    3: begin
                        // Straddle the dead band edge
                        shunt = 16'({1'b0, zb} + $urandom_range(0, 1));
                        if ($urandom_range(0, 1))
                            shunt = -shunt;
                    end
                    default: shunt = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                endcase
                bus = $urandom_range(0, 1) ? 15'($urandom_range(0, 32767))
                                           : 15'($urandom_range(0, 200));
                send_reading(shunt, bus);
            end
            drain();
            no_idle = 1'b0;
        end

        // Let any stray word show up, then report
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (sb.expected_q.size() != 0) begin
            $display("%0t: expected word never arrived, expected %h, actual none",
                     $time, sb.expected_q.pop_front());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("power_monitor_reading_conversion_top regression: pass");
        else
            $display("power_monitor_reading_conversion_top regression: fail");
        $finish;
    end

endmodule
